### rtl/ata_pkg.sv
package ata_pkg;

    // default for the fraction bits of the angle result
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    localparam int AXIS_W    = 17;   // offset-corrected axis, exact
    localparam int SQ_W      = 33;   // square of one axis magnitude
    localparam int S2_W      = 34;   // x^2 + z^2
    localparam int SCALE_W   = 5;
    localparam int MAX_SCALE = 28;
    localparam int RAD_W     = 60;   // normalized radicand
    localparam int ROOT_W    = 30;   // square root of the radicand
    localparam int CW        = 48;   // cordic coordinates
    localparam int AW        = 36;   // cordic angle, signed, 32 fraction bits
    localparam int ANG_W     = 34;   // unsigned angle 0 .. pi
    localparam int CORDIC_STEPS = 32;
    localparam int DEG_MUL   = 45;   // 180 = 45 * 4

    // radians with 32 fraction bits
    localparam logic [ANG_W-1:0] PI_Q32      = 34'd13493037705;
    localparam logic [ANG_W-1:0] HALF_PI_Q32 = 34'd6746518852;
    localparam logic [ANG_W-1:0] PI_Q32_HALF = PI_Q32 >> 1;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    typedef struct packed {
        logic [15:0] tilt_angle;
        logic        zero_vector;
    } result_t;

    // what rides along the square root pipeline
    typedef struct packed {
        logic signed [CW-1:0] big_y;
        logic                 zero;
    } side_t;

    // atan(2^-step) in radians, 32 fraction bits, rounded
    function automatic logic [ANG_W-1:0] atan_q32(input int step);
        logic [ANG_W-1:0] val;
        case (step)
            0:       val = 34'd3373259426;
            1:       val = 34'd1991351318;
            2:       val = 34'd1052175346;
            3:       val = 34'd534100635;
            4:       val = 34'd268086748;
            5:       val = 34'd134174063;
            6:       val = 34'd67103403;
            7:       val = 34'd33553749;
            8:       val = 34'd16777131;
            9:       val = 34'd8388597;
            10:      val = 34'd4194303;
            default: val = ANG_W'(1) << (32 - step);
        endcase
        return val;
    endfunction

endpackage

### rtl/accel_tilt_angle_top.sv
// tilt angle of a three-axis accelerometer sample against the y axis
//
// sample channel: a transaction is taken at each rising edge with start high
// and busy low. busy stays low, so one sample can be taken every cycle.
// result channel: done is high for exactly one cycle with result valid; the
// receiver must take it then, nothing downstream can hold the pipeline.
// config channel: cfg_data is the signed axis offset, written on
// cfg_valid && cfg_ready; cfg_ready is always high. write it only while no
// sample is in flight.
// stages between the accepting edge and done, for any ANGLE_FRAC_BITS: 2 lane
// stages, 3 merge stages, 30 square root stages, 33 cordic stages and 5 stages
// of clamp, reciprocal estimate, product by pi, remainder, and correction by pi
// with the output register. throughput is one transaction per cycle, every
// stage being a register of a fully pipelined datapath.
// reset: all valid flags clear, so nothing is in flight, and the offset
// returns to 125.
module accel_tilt_angle_top
    import ata_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sample_t            sample,
    output logic               done,
    output result_t            result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [15:0] cfg_data
);

    localparam int LATENCY     = 73;
    localparam int ANGLE_FULL  = 180 << ANGLE_FRAC_BITS;
    localparam logic [15:0] ANGLE_MAX =
        (ANGLE_FULL > 65535) ? 16'hFFFF : 16'(ANGLE_FULL);

    logic signed [15:0] offset_reg;
    logic               lane_v1_reg;
    logic               lane_v2_reg;

    logic signed [AXIS_W-1:0] corr_x;
    logic signed [AXIS_W-1:0] corr_y;
    logic signed [AXIS_W-1:0] corr_z;
    logic        [SQ_W-1:0]   sq_x;
    logic        [SQ_W-1:0]   sq_z;

    logic              merge_valid;
    logic [RAD_W-1:0]  rad;
    side_t             merge_side;

    logic              root_valid;
    logic [ROOT_W-1:0] root;
    side_t             root_side;

    logic                 rot_valid;
    logic signed [AW-1:0] rot_angle;
    logic                 rot_zero;

    // fully pipelined: never stalls on either side
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // offset register and the valid flags of the lane stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 16'sd125;
            lane_v1_reg <= 1'b0;
            lane_v2_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                offset_reg <= cfg_data;
            end
            lane_v1_reg <= start && !busy;
            lane_v2_reg <= lane_v1_reg;
        end
    end

    // one lane per axis: offset correction, magnitude and square
    ata_lane u_lane_x
    (
        .clk    (clk),
        .raw    (sample.accel_x),
        .offset (offset_reg),
        .corr   (corr_x),
        .mag_sq (sq_x)
    );

    // y only needs its corrected value, the square output is left open
    ata_lane u_lane_y
    (
        .clk    (clk),
        .raw    (sample.accel_y),
        .offset (offset_reg),
        .corr   (corr_y),
        .mag_sq ()
    );

    ata_lane u_lane_z
    (
        .clk    (clk),
        .raw    (sample.accel_z),
        .offset (offset_reg),
        .corr   (corr_z),
        .mag_sq (sq_z)
    );

    // sum of squares, zero detect, normalizing scale
    ata_merge u_merge
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_v2_reg),
        .corr_x    (corr_x),
        .corr_y    (corr_y),
        .corr_z    (corr_z),
        .sq_x      (sq_x),
        .sq_z      (sq_z),
        .out_valid (merge_valid),
        .rad       (rad),
        .side      (merge_side)
    );

    // floor square root of the scaled x^2 + z^2
    ata_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (merge_valid),
        .rad       (rad),
        .side_in   (merge_side),
        .out_valid (root_valid),
        .root      (root),
        .side_out  (root_side)
    );

    // atan2(root, y) by vectoring
    ata_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .root      (root),
        .side_in   (root_side),
        .out_valid (rot_valid),
        .angle     (rot_angle),
        .zero      (rot_zero)
    );

    // radians to degrees with ANGLE_FRAC_BITS fraction bits
    ata_deg #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_deg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rot_valid),
        .angle    (rot_angle),
        .zero     (rot_zero),
        .done     (done),
        .result   (result)
    );

    // every taken sample comes out after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing after a taken sample");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching sample");

    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_vector) |-> (result.tilt_angle == '0))
        else $error("zero vector with nonzero angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.zero_vector) |-> (result.tilt_angle <= ANGLE_MAX))
        else $error("angle beyond 180 degrees");

endmodule

### rtl/ata_lane.sv
module ata_lane
    import ata_pkg::*;
(
    input  logic                     clk,
    input  logic signed [15:0]       raw,
    input  logic signed [15:0]       offset,
    output logic signed [AXIS_W-1:0] corr,
    output logic        [SQ_W-1:0]   mag_sq
);

    logic signed [AXIS_W-1:0] corr_reg;
    logic signed [AXIS_W-1:0] corr_next;
    logic signed [AXIS_W-1:0] corr_d_reg;
    logic        [AXIS_W-1:0] mag;
    logic        [SQ_W-1:0]   mag_sq_reg;
    logic        [SQ_W-1:0]   mag_sq_next;

    always_comb
    begin
        corr_next   = AXIS_W'(raw) + AXIS_W'(offset);
        // most negative value reads back as 2^16 unsigned
        mag         = corr_reg[AXIS_W-1] ? AXIS_W'(-corr_reg) : AXIS_W'(corr_reg);
        mag_sq_next = SQ_W'(mag) * SQ_W'(mag);
    end

    always_ff @(posedge clk)
    begin
        corr_reg   <= corr_next;
        corr_d_reg <= corr_reg;
        mag_sq_reg <= mag_sq_next;
    end

    assign corr   = corr_d_reg;
    assign mag_sq = mag_sq_reg;

endmodule

### rtl/ata_merge.sv
module ata_merge
    import ata_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [AXIS_W-1:0] corr_x,
    input  logic signed [AXIS_W-1:0] corr_y,
    input  logic signed [AXIS_W-1:0] corr_z,
    input  logic        [SQ_W-1:0]   sq_x,
    input  logic        [SQ_W-1:0]   sq_z,
    output logic                     out_valid,
    output logic        [RAD_W-1:0]  rad,
    output side_t                    side
);

    function automatic logic [5:0] bit_len(input logic [S2_W-1:0] v);
        logic [5:0] len;
        len = '0;
        for (int i = 0; i < S2_W; i++)
        begin
            if (v[i])
            begin
                len = 6'(i + 1);
            end
        end
        return len;
    endfunction

    logic                     m1_valid_reg;
    logic        [S2_W-1:0]   s2_reg;
    logic signed [AXIS_W-1:0] y1_reg;
    logic                     zero1_reg;

    logic                     m2_valid_reg;
    logic        [S2_W-1:0]   s2b_reg;
    logic signed [AXIS_W-1:0] y2_reg;
    logic                     zero2_reg;
    logic        [SCALE_W-1:0] scale_reg;
    logic        [SCALE_W-1:0] scale_next;
    logic        [5:0]         len;

    logic                     m3_valid_reg;
    logic        [RAD_W-1:0]  rad_reg;
    side_t                    side_reg;

    // largest scale, at most MAX_SCALE, that keeps the radicand below 2^60
    always_comb
    begin
        len = bit_len(s2_reg);
        if (len <= 6'(RAD_W - 2 * MAX_SCALE))
        begin
            scale_next = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale_next = SCALE_W'((6'(RAD_W) - len) >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg    <= S2_W'(sq_x) + S2_W'(sq_z);
        y1_reg    <= corr_y;
        zero1_reg <= (corr_x == '0) && (corr_y == '0) && (corr_z == '0);

        s2b_reg   <= s2_reg;
        y2_reg    <= y1_reg;
        zero2_reg <= zero1_reg;
        scale_reg <= scale_next;

        rad_reg        <= RAD_W'(s2b_reg) << {scale_reg, 1'b0};
        side_reg.big_y <= CW'(y2_reg) <<< scale_reg;
        side_reg.zero  <= zero2_reg;
    end

    assign out_valid = m3_valid_reg;
    assign rad       = rad_reg;
    assign side      = side_reg;

endmodule

### rtl/ata_isqrt.sv
module ata_isqrt
    import ata_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  rad,
    input  side_t             side_in,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output side_t             side_out
);

    localparam int REM_W = ROOT_W + 1;

    logic [RAD_W-1:0]  rad_reg   [ROOT_W-1];
    logic [REM_W-1:0]  rem_reg   [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];
    side_t             side_reg  [ROOT_W];

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic              v_in;
        side_t             side_i;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  test;
        logic              take;

        if (k == 0)
        begin : g_src
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = in_valid;
            assign side_i  = side_in;
        end
        else
        begin : g_src
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = valid_reg[k-1];
            assign side_i  = side_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, rad_in[RAD_W-1 -: 2]};
            test  = (REM_W + 2)'({root_in, 2'b01});
            take  = trial >= test;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[k] <= {root_in[ROOT_W-2:0], take};
            side_reg[k] <= side_i;
        end

        if (k < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rad_reg[k] <= rad_in << 2;
                rem_reg[k] <= take ? REM_W'(trial - test) : REM_W'(trial);
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

### rtl/ata_cordic.sv
module ata_cordic
    import ata_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [ROOT_W-1:0]    root,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic signed [AW-1:0] angle,
    output logic                 zero
);

    logic signed [CW-1:0] x_reg     [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_reg     [CORDIC_STEPS+1];
    logic signed [AW-1:0] a_reg     [CORDIC_STEPS+1];
    logic                 valid_reg [CORDIC_STEPS+1];
    logic                 zero_reg  [CORDIC_STEPS+1];

    // start vector: fold a negative y into the upper half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg[0] <= side_in.zero;
        if (side_in.big_y < 0)
        begin
            x_reg[0] <= CW'(root);
            y_reg[0] <= -side_in.big_y;
            a_reg[0] <= AW'(HALF_PI_Q32);
        end
        else
        begin
            x_reg[0] <= side_in.big_y;
            y_reg[0] <= CW'(root);
            a_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++)
    begin : g_rot
        localparam int SH = k - 1;
        localparam logic signed [AW-1:0] ATAN_K = AW'(atan_q32(SH));

        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;

        always_comb
        begin
            dx = y_reg[k-1] >>> SH;
            dy = x_reg[k-1] >>> SH;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[k] <= zero_reg[k-1];
            if (y_reg[k-1] > 0)
            begin
                x_reg[k] <= x_reg[k-1] + dx;
                y_reg[k] <= y_reg[k-1] - dy;
                a_reg[k] <= a_reg[k-1] + ATAN_K;
            end
            else
            begin
                x_reg[k] <= x_reg[k-1] - dx;
                y_reg[k] <= y_reg[k-1] + dy;
                a_reg[k] <= a_reg[k-1] - ATAN_K;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign angle     = a_reg[CORDIC_STEPS];
    assign zero      = zero_reg[CORDIC_STEPS];

endmodule

### rtl/ata_deg.sv
module ata_deg
    import ata_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [AW-1:0] angle,
    input  logic                 zero,
    output logic                 done,
    output result_t              result
);

    localparam int QW    = 8 + ANGLE_FRAC_BITS;        // quotient bits
    localparam int MW    = ANG_W + 6;                  // angle * 45
    localparam int NW    = MW + ANGLE_FRAC_BITS + 2;   // dividend
    localparam int XW    = QW + 16;
    localparam int PW    = 2 * QW;                     // estimate product
    localparam int RW    = ANG_W + 2;                  // remainder, below 4 * pi
    localparam int TRUNC = 26 - ANGLE_FRAC_BITS;       // angle bits dropped for the estimate

    // reciprocal of pi scaled so that the estimate is at most 3 low
    localparam logic [79:0] RECIP_WIDE =
        (80'd180 << (34 + ANGLE_FRAC_BITS)) / {46'd0, PI_Q32};
    localparam logic [QW-1:0] RECIP = RECIP_WIDE[QW-1:0];

    localparam logic [RW-1:0] PI_X1 = RW'(PI_Q32);
    localparam logic [RW-1:0] PI_X2 = PI_X1 << 1;
    localparam logic [RW-1:0] PI_X3 = PI_X1 + PI_X2;

    logic             c_valid_reg;
    logic [ANG_W-1:0] a_reg;
    logic [ANG_W-1:0] a_next;
    logic             c_zero_reg;

    logic             p_valid_reg;
    logic [PW-1:0]    est_reg;
    logic [NW-1:0]    num_reg;
    logic             p_zero_reg;

    logic             e_valid_reg;
    logic [QW-1:0]    qe_reg;
    logic [NW-1:0]    qp_reg;
    logic [NW-1:0]    num_e_reg;
    logic             e_zero_reg;

    logic             r_valid_reg;
    logic [QW-1:0]    qr_reg;
    logic [RW-1:0]    rem_reg;
    logic             r_zero_reg;

    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;
    logic [QW-1:0]    q_est;
    logic [NW-1:0]    diff;
    logic [XW-1:0]    q_ext;

    always_comb
    begin
        if (angle < 0)
        begin
            a_next = '0;
        end
        else if (angle > $signed({2'b00, PI_Q32}))
        begin
            a_next = PI_Q32;
        end
        else
        begin
            a_next = angle[ANG_W-1:0];
        end
    end

    always_comb
    begin
        q_est = est_reg[PW-1:QW];
        diff  = num_e_reg - qp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= in_valid;
            p_valid_reg <= c_valid_reg;
            e_valid_reg <= p_valid_reg;
            r_valid_reg <= e_valid_reg;
        end
    end

    // quotient estimate by reciprocal, exact remainder, then up to three steps of pi
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        c_zero_reg <= zero;

        est_reg    <= PW'(a_reg[ANG_W-1:TRUNC]) * PW'(RECIP);
        num_reg    <= {MW'(a_reg) * MW'(DEG_MUL), {(ANGLE_FRAC_BITS + 2){1'b0}}}
                      + NW'(PI_Q32_HALF);
        p_zero_reg <= c_zero_reg;

        qe_reg     <= q_est;
        qp_reg     <= NW'(q_est) * NW'(PI_Q32);
        num_e_reg  <= num_reg;
        e_zero_reg <= p_zero_reg;

        qr_reg     <= qe_reg;
        rem_reg    <= diff[RW-1:0];
        r_zero_reg <= e_zero_reg;
    end

    always_comb
    begin
        q_ext = XW'(qr_reg) + XW'(rem_reg >= PI_X1) + XW'(rem_reg >= PI_X2)
                + XW'(rem_reg >= PI_X3);
        result_next.zero_vector = r_zero_reg;
        if (r_zero_reg)
        begin
            result_next.tilt_angle = '0;
        end
        else if (q_ext > XW'(16'hFFFF))
        begin
            result_next.tilt_angle = 16'hFFFF;
        end
        else
        begin
            result_next.tilt_angle = q_ext[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
